// ===== rtl/gti_pkg.sv =====
// shared types, constants and helper functions for the trilinear grid table
`default_nettype none

package gti_pkg;

   // grid geometry and weight precision
   localparam int unsigned GRID_POINTS      = 16;
   localparam int unsigned WEIGHT_FRAC_BITS = 12;

   // field widths
   localparam int unsigned EFF_W      = 16;
   localparam int unsigned IDX_W      = 4;
   localparam int unsigned HEAD_VAL_W = 12;
   localparam int unsigned FLOW_VAL_W = 14;
   localparam int unsigned VANE_VAL_W = 11;

   // axis minimum and span, 4 fraction bits
   localparam int unsigned HEAD_BASE = 1280;
   localparam int unsigned HEAD_SPAN = 1280;
   localparam int unsigned FLOW_BASE = 4800;
   localparam int unsigned FLOW_SPAN = 9600;
   localparam int unsigned VANE_BASE = 240;
   localparam int unsigned VANE_SPAN = 1120;

   // grid position: (GRID_POINTS-1) points with WEIGHT_FRAC_BITS fraction bits
   localparam longint unsigned POS_SCALE =
      longint'(GRID_POINTS - 1) << WEIGHT_FRAC_BITS;
   localparam longint unsigned POS_TOP = POS_SCALE - 1;
   localparam int unsigned CORNER_W = (GRID_POINTS > 2) ? $clog2(GRID_POINTS - 1) : 1;
   localparam int unsigned POS_W    = WEIGHT_FRAC_BITS + CORNER_W;
   localparam int unsigned WEIGHT_ONE = 1 << WEIGHT_FRAC_BITS;

   // exact division by span: floor(n / span) = (n * RECIP) >> SHIFT for n < 2^N_W
   localparam int unsigned HEAD_D_W = $clog2(HEAD_SPAN);
   localparam int unsigned HEAD_N_W = $clog2(POS_SCALE * HEAD_SPAN);
   localparam int unsigned HEAD_SHIFT = HEAD_N_W + HEAD_D_W;
   localparam longint unsigned HEAD_RECIP =
      ((64'd1 << HEAD_SHIFT) + HEAD_SPAN - 1) / HEAD_SPAN;
   localparam int unsigned HEAD_R_W = $clog2(HEAD_RECIP + 1);

   localparam int unsigned FLOW_D_W = $clog2(FLOW_SPAN);
   localparam int unsigned FLOW_N_W = $clog2(POS_SCALE * FLOW_SPAN);
   localparam int unsigned FLOW_SHIFT = FLOW_N_W + FLOW_D_W;
   localparam longint unsigned FLOW_RECIP =
      ((64'd1 << FLOW_SHIFT) + FLOW_SPAN - 1) / FLOW_SPAN;
   localparam int unsigned FLOW_R_W = $clog2(FLOW_RECIP + 1);

   localparam int unsigned VANE_D_W = $clog2(VANE_SPAN);
   localparam int unsigned VANE_N_W = $clog2(POS_SCALE * VANE_SPAN);
   localparam int unsigned VANE_SHIFT = VANE_N_W + VANE_D_W;
   localparam longint unsigned VANE_RECIP =
      ((64'd1 << VANE_SHIFT) + VANE_SPAN - 1) / VANE_SPAN;
   localparam int unsigned VANE_R_W = $clog2(VANE_RECIP + 1);

   // table banked by index parity on all three axes: eight corners, eight banks
   localparam int unsigned BANKS      = 8;
   localparam int unsigned HALF       = (GRID_POINTS + 1) / 2;
   localparam int unsigned HALF_W     = (HALF > 1) ? $clog2(HALF) : 1;
   localparam int unsigned BANK_DEPTH = HALF * HALF * HALF;
   localparam int unsigned BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   typedef logic [EFF_W-1:0]            word_type;
   typedef logic [IDX_W-1:0]            idx_type;
   typedef logic [HEAD_VAL_W-1:0]       head_val_type;
   typedef logic [FLOW_VAL_W-1:0]       flow_val_type;
   typedef logic [VANE_VAL_W-1:0]       vane_val_type;
   typedef logic [HEAD_D_W-1:0]         head_d_type;
   typedef logic [FLOW_D_W-1:0]         flow_d_type;
   typedef logic [VANE_D_W-1:0]         vane_d_type;
   typedef logic [HEAD_N_W-1:0]         head_n_type;
   typedef logic [FLOW_N_W-1:0]         flow_n_type;
   typedef logic [VANE_N_W-1:0]         vane_n_type;
   typedef logic [HEAD_N_W+HEAD_R_W-1:0] head_prod_type;
   typedef logic [FLOW_N_W+FLOW_R_W-1:0] flow_prod_type;
   typedef logic [VANE_N_W+VANE_R_W-1:0] vane_prod_type;
   typedef logic [POS_W-1:0]            pos_type;
   typedef logic [CORNER_W-1:0]         corner_type;
   typedef logic [WEIGHT_FRAC_BITS-1:0] weight_type;
   typedef logic [WEIGHT_FRAC_BITS:0]   weight_comp_type;
   typedef logic [EFF_W+WEIGHT_FRAC_BITS-1:0] blend_sum_type;
   typedef logic [HALF_W-1:0]           half_type;
   typedef logic [BANK_AW-1:0]          bank_addr_type;
   typedef logic [2:0]                  bank_sel_type;
   typedef word_type [BANKS-1:0]        corner_vec_type;

   // one accepted item as it enters the block
   typedef struct packed {
      cmd_type      cmd;
      idx_type      h_idx;
      idx_type      q_idx;
      idx_type      v_idx;
      word_type     entry;
      head_val_type head_value;
      flow_val_type flow_value;
      vane_val_type vane_value;
   } req_item_type;

   // part of an item that rides along the position pipeline
   typedef struct packed {
      cmd_type  cmd;
      idx_type  h_idx;
      idx_type  q_idx;
      idx_type  v_idx;
      word_type entry;
   } tag_type;

   typedef struct packed {
      tag_type tag;
      pos_type pos_h;
      pos_type pos_q;
      pos_type pos_v;
   } pos_item_type;

   typedef struct packed {
      weight_type fh;
      weight_type fq;
      weight_type fv;
   } weights_type;

   // (a * (1 - f) + b * f) >> W; result stays between a and b
   function automatic word_type blend_pair(word_type a, word_type b, weight_type f);
      weight_comp_type g;
      blend_sum_type   pa;
      blend_sum_type   pb;
      blend_sum_type   sum;
      g   = weight_comp_type'(WEIGHT_ONE) - weight_comp_type'(f);
      pa  = a * g;
      pb  = b * f;
      sum = pa + pb;
      return sum[WEIGHT_FRAC_BITS +: EFF_W];
   endfunction

   // half index of the corner with parity p, given the lower corner index
   function automatic half_type half_of(corner_type i0, logic p);
      corner_type h;
      h = corner_type'(i0 >> 1) + corner_type'(i0[0] & ~p);
      return half_type'(h);
   endfunction

   function automatic bank_addr_type bank_addr(half_type h, half_type q, half_type v);
      return bank_addr_type'((int'(h) * HALF + int'(q)) * HALF + int'(v));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gti_req_if.sv =====
// request channel: load or lookup items with valid/ready handshake
`default_nettype none

interface gti_req_if;
   logic                  valid;
   logic                  ready;
   logic                  command;
   gti_pkg::idx_type      head_index;
   gti_pkg::idx_type      flow_index;
   gti_pkg::idx_type      vane_index;
   gti_pkg::word_type     entry_value;
   gti_pkg::head_val_type head_value;
   gti_pkg::flow_val_type flow_value;
   gti_pkg::vane_val_type vane_value;

   modport source (
      output valid, command, head_index, flow_index, vane_index,
      output entry_value, head_value, flow_value, vane_value,
      input  ready
   );

   modport sink (
      input  valid, command, head_index, flow_index, vane_index,
      input  entry_value, head_value, flow_value, vane_value,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/gti_rsp_if.sv =====
// response channel: interpolated efficiency items with valid/ready handshake
`default_nettype none

interface gti_rsp_if;
   logic              valid;
   logic              ready;
   gti_pkg::word_type efficiency;

   modport source (
      output valid, efficiency,
      input  ready
   );

   modport sink (
      input  valid, efficiency,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/gti_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
`default_nettype none

module gti_ram #(
   parameter  int unsigned WIDTH = 16,
   parameter  int unsigned DEPTH = 512,
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/gti_pos.sv =====
// three-stage grid position pipeline: offset, scale, divide by span and clamp
`default_nettype none

module gti_pos (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  gti_pkg::req_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output gti_pkg::pos_item_type out_item
);

   // stage valids
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic rdy1, rdy2, rdy3;

   // stage 1: offset from axis minimum, below / above flags
   gti_pkg::tag_type    tag1_ff, tag2_ff;
   gti_pkg::head_d_type d1_h_ff, d1_h_in;
   gti_pkg::flow_d_type d1_q_ff, d1_q_in;
   gti_pkg::vane_d_type d1_v_ff, d1_v_in;
   logic [2:0]          lo1_ff, lo1_in, hi1_ff, hi1_in;

   // stage 2: offset times scale
   gti_pkg::head_n_type n2_h_ff, n2_h_in;
   gti_pkg::flow_n_type n2_q_ff, n2_q_in;
   gti_pkg::vane_n_type n2_v_ff, n2_v_in;
   logic [2:0]          lo2_ff, hi2_ff;

   // stage 3: position after exact reciprocal division and clamp
   gti_pkg::pos_item_type s3_ff, s3_in;
   gti_pkg::head_prod_type prod_h;
   gti_pkg::flow_prod_type prod_q;
   gti_pkg::vane_prod_type prod_v;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign v1_in = rdy1 ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_comb begin
      lo1_in[2] = int'(in_item.head_value) <= int'(gti_pkg::HEAD_BASE);
      lo1_in[1] = int'(in_item.flow_value) <= int'(gti_pkg::FLOW_BASE);
      lo1_in[0] = int'(in_item.vane_value) <= int'(gti_pkg::VANE_BASE);
      hi1_in[2] = int'(in_item.head_value) >= int'(gti_pkg::HEAD_BASE + gti_pkg::HEAD_SPAN);
      hi1_in[1] = int'(in_item.flow_value) >= int'(gti_pkg::FLOW_BASE + gti_pkg::FLOW_SPAN);
      hi1_in[0] = int'(in_item.vane_value) >= int'(gti_pkg::VANE_BASE + gti_pkg::VANE_SPAN);
      d1_h_in = gti_pkg::head_d_type'(int'(in_item.head_value) - int'(gti_pkg::HEAD_BASE));
      d1_q_in = gti_pkg::flow_d_type'(int'(in_item.flow_value) - int'(gti_pkg::FLOW_BASE));
      d1_v_in = gti_pkg::vane_d_type'(int'(in_item.vane_value) - int'(gti_pkg::VANE_BASE));
   end

   always_comb begin
      n2_h_in = gti_pkg::head_n_type'(d1_h_ff * gti_pkg::POS_SCALE);
      n2_q_in = gti_pkg::flow_n_type'(d1_q_ff * gti_pkg::POS_SCALE);
      n2_v_in = gti_pkg::vane_n_type'(d1_v_ff * gti_pkg::POS_SCALE);
   end

   always_comb begin
      prod_h = gti_pkg::head_prod_type'(n2_h_ff * gti_pkg::HEAD_RECIP);
      prod_q = gti_pkg::flow_prod_type'(n2_q_ff * gti_pkg::FLOW_RECIP);
      prod_v = gti_pkg::vane_prod_type'(n2_v_ff * gti_pkg::VANE_RECIP);
      s3_in.tag = tag2_ff;
      priority if (lo2_ff[2]) begin
         s3_in.pos_h = '0;
      end else if (hi2_ff[2]) begin
         s3_in.pos_h = gti_pkg::pos_type'(gti_pkg::POS_TOP);
      end else begin
         s3_in.pos_h = gti_pkg::pos_type'(prod_h >> gti_pkg::HEAD_SHIFT);
      end
      priority if (lo2_ff[1]) begin
         s3_in.pos_q = '0;
      end else if (hi2_ff[1]) begin
         s3_in.pos_q = gti_pkg::pos_type'(gti_pkg::POS_TOP);
      end else begin
         s3_in.pos_q = gti_pkg::pos_type'(prod_q >> gti_pkg::FLOW_SHIFT);
      end
      priority if (lo2_ff[0]) begin
         s3_in.pos_v = '0;
      end else if (hi2_ff[0]) begin
         s3_in.pos_v = gti_pkg::pos_type'(gti_pkg::POS_TOP);
      end else begin
         s3_in.pos_v = gti_pkg::pos_type'(prod_v >> gti_pkg::VANE_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         tag1_ff <= '{cmd: in_item.cmd, h_idx: in_item.h_idx, q_idx: in_item.q_idx,
                      v_idx: in_item.v_idx, entry: in_item.entry};
         d1_h_ff <= d1_h_in;
         d1_q_ff <= d1_q_in;
         d1_v_ff <= d1_v_in;
         lo1_ff  <= lo1_in;
         hi1_ff  <= hi1_in;
      end
      if (rdy2 && v1_ff) begin
         tag2_ff <= tag1_ff;
         n2_h_ff <= n2_h_in;
         n2_q_ff <= n2_q_in;
         n2_v_ff <= n2_v_in;
         lo2_ff  <= lo1_ff;
         hi2_ff  <= hi1_ff;
      end
      if (rdy3 && v2_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = s3_ff;

   // a stalled position must hold until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !out_ready |=> v3_ff && $stable(s3_ff))
      else $error("position item changed while stalled");

   // positions never reach the last grid point
   a_top: assert property (@(posedge clock) disable iff (reset)
      v3_ff && s3_ff.tag.cmd == gti_pkg::CMD_LOOKUP |->
         s3_ff.pos_h <= gti_pkg::pos_type'(gti_pkg::POS_TOP) &&
         s3_ff.pos_q <= gti_pkg::pos_type'(gti_pkg::POS_TOP) &&
         s3_ff.pos_v <= gti_pkg::pos_type'(gti_pkg::POS_TOP))
      else $error("grid position beyond clamp");

   // input stalls only when every stage is full and the output is blocked
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> v1_ff && v2_ff && v3_ff && !out_ready)
      else $error("position pipeline refused an item with room");

endmodule

`default_nettype wire

// ===== rtl/gti_blend.sv =====
// blend pipeline: four vane blends, two flow blends, one head blend, output register
`default_nettype none

module gti_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  gti_pkg::corner_vec_type in_corners,
   input  gti_pkg::weights_type    in_weights,
   output logic                    out_valid,
   input  logic                    out_ready,
   output gti_pkg::word_type       out_data
);

   logic v5_ff, v5_in;
   logic v6_ff, v6_in;
   logic vo_ff, vo_in;
   logic rdy5, rdy6, rdyo;

   gti_pkg::word_type [3:0] c5_ff, c5_in;
   gti_pkg::weight_type     fh5_ff, fq5_ff;
   gti_pkg::word_type [1:0] c6_ff, c6_in;
   gti_pkg::weight_type     fh6_ff;
   gti_pkg::word_type       eff_ff, eff_in;

   assign rdyo     = !vo_ff || out_ready;
   assign rdy6     = !v6_ff || rdyo;
   assign rdy5     = !v5_ff || rdy6;
   assign in_ready = rdy5;

   assign v5_in = rdy5 ? in_valid : v5_ff;
   assign v6_in = rdy6 ? v5_ff : v6_ff;
   assign vo_in = rdyo ? v6_ff : vo_ff;

   // corner k pairs along vane: {dh, dq} selects the pair
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         c5_in[k] = gti_pkg::blend_pair(in_corners[2*k], in_corners[2*k+1], in_weights.fv);
      end
      c6_in[0] = gti_pkg::blend_pair(c5_ff[0], c5_ff[1], fq5_ff);
      c6_in[1] = gti_pkg::blend_pair(c5_ff[2], c5_ff[3], fq5_ff);
      eff_in   = gti_pkg::blend_pair(c6_ff[0], c6_ff[1], fh6_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v5_ff <= v5_in;
         v6_ff <= v6_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5 && in_valid) begin
         c5_ff  <= c5_in;
         fh5_ff <= in_weights.fh;
         fq5_ff <= in_weights.fq;
      end
      if (rdy6 && v5_ff) begin
         c6_ff  <= c6_in;
         fh6_ff <= fh5_ff;
      end
      if (rdyo && v6_ff) begin
         eff_ff <= eff_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_data  = eff_ff;

   a_take: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> v5_ff)
      else $error("accepted corners lost");

   a_flow_hold: assert property (@(posedge clock) disable iff (reset)
      v6_ff && !rdyo |=> v6_ff && $stable(c6_ff))
      else $error("flow blend changed while stalled");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      vo_ff && out_ready && !v6_ff |=> !vo_ff)
      else $error("result repeated");

endmodule

`default_nettype wire

// ===== rtl/grid_table_trilinear_interp_unit.sv =====
// top level: banked efficiency table with position and blend pipelines
// throughput: one item per cycle, load or lookup, while the response channel is not
//   stalling the pipelines; each of the eight corners is read from its own parity
//   bank, so one read per bank port per cycle suffices
// reset: synchronous, clears only pipeline valid bits; table entries hold no
//   value until written and need no clearing pass
`default_nettype none

module grid_table_trilinear_interp_unit (
   input  logic       clock,
   input  logic       reset,
   gti_req_if.sink    req_chan,
   gti_rsp_if.source  rsp_chan
);

   // request payload gathered into one item
   gti_pkg::req_item_type req_item;

   // position pipeline output
   logic                  pos_valid;
   logic                  pos_ready;
   gti_pkg::pos_item_type pos_item;

   // table access stage: lookup valid, weights and corner parities
   logic                  v4_ff, v4_in;
   logic                  rdy4;
   gti_pkg::weights_type  w4_ff, w4_in;
   gti_pkg::bank_sel_type par4_ff, par4_in;

   // bank ports
   logic                   is_lookup;
   logic                   in_range;
   logic                   ram_rd_en;
   logic                   ram_wr_en;
   gti_pkg::bank_sel_type  wr_sel;
   gti_pkg::bank_addr_type wr_addr;
   gti_pkg::corner_type    h0, q0, v0;
   gti_pkg::word_type      bank_rd_data [gti_pkg::BANKS];
   gti_pkg::corner_vec_type corners;

   // blend pipeline handshake
   logic blend_ready;

   assign req_item = '{
      cmd:        gti_pkg::cmd_type'(req_chan.command),
      h_idx:      req_chan.head_index,
      q_idx:      req_chan.flow_index,
      v_idx:      req_chan.vane_index,
      entry:      req_chan.entry_value,
      head_value: req_chan.head_value,
      flow_value: req_chan.flow_value,
      vane_value: req_chan.vane_value
   };

   gti_pos u_pos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_item   (req_item),
      .out_valid (pos_valid),
      .out_ready (pos_ready),
      .out_item  (pos_item)
   );

   // loads and lookups leave the position pipeline in order and touch the
   // banks at this one point, so a lookup always sees every earlier load
   assign rdy4      = !v4_ff || blend_ready;
   assign pos_ready = rdy4;
   assign is_lookup = pos_item.tag.cmd == gti_pkg::CMD_LOOKUP;
   assign in_range  = int'(pos_item.tag.h_idx) < int'(gti_pkg::GRID_POINTS) &&
                      int'(pos_item.tag.q_idx) < int'(gti_pkg::GRID_POINTS) &&
                      int'(pos_item.tag.v_idx) < int'(gti_pkg::GRID_POINTS);
   assign ram_rd_en = pos_valid && is_lookup && rdy4;
   assign ram_wr_en = pos_valid && !is_lookup && rdy4 && in_range;

   // lower corner indices from the integer part of each position
   assign h0 = gti_pkg::corner_type'(pos_item.pos_h >> gti_pkg::WEIGHT_FRAC_BITS);
   assign q0 = gti_pkg::corner_type'(pos_item.pos_q >> gti_pkg::WEIGHT_FRAC_BITS);
   assign v0 = gti_pkg::corner_type'(pos_item.pos_v >> gti_pkg::WEIGHT_FRAC_BITS);

   // load goes to the bank named by its index parities, at the halved index
   assign wr_sel  = {pos_item.tag.h_idx[0], pos_item.tag.q_idx[0], pos_item.tag.v_idx[0]};
   assign wr_addr = gti_pkg::bank_addr(gti_pkg::half_type'(pos_item.tag.h_idx >> 1),
                                       gti_pkg::half_type'(pos_item.tag.q_idx >> 1),
                                       gti_pkg::half_type'(pos_item.tag.v_idx >> 1));

   for (genvar b = 0; b < gti_pkg::BANKS; b++) begin : g_bank
      localparam logic HP = logic'((b >> 2) & 1);
      localparam logic QP = logic'((b >> 1) & 1);
      localparam logic VP = logic'(b & 1);

      gti_pkg::bank_addr_type rd_addr;

      // each bank holds exactly one of the eight corners of any cell
      assign rd_addr = gti_pkg::bank_addr(gti_pkg::half_of(h0, HP),
                                          gti_pkg::half_of(q0, QP),
                                          gti_pkg::half_of(v0, VP));

      gti_ram #(
         .WIDTH (gti_pkg::EFF_W),
         .DEPTH (gti_pkg::BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_wr_en && wr_sel == gti_pkg::bank_sel_type'(b)),
         .wr_addr (wr_addr),
         .wr_data (pos_item.tag.entry),
         .rd_en   (ram_rd_en),
         .rd_addr (rd_addr),
         .rd_data (bank_rd_data[b])
      );
   end

   always_comb begin
      v4_in   = rdy4 ? (pos_valid && is_lookup) : v4_ff;
      w4_in   = '{fh: pos_item.pos_h[gti_pkg::WEIGHT_FRAC_BITS-1:0],
                  fq: pos_item.pos_q[gti_pkg::WEIGHT_FRAC_BITS-1:0],
                  fv: pos_item.pos_v[gti_pkg::WEIGHT_FRAC_BITS-1:0]};
      par4_in = {h0[0], q0[0], v0[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
      end
   end

   // read data stays in the bank output registers while this stage stalls
   always_ff @(posedge clock) begin
      if (ram_rd_en) begin
         w4_ff   <= w4_in;
         par4_ff <= par4_in;
      end
   end

   // corner {dh, dq, dv} sits in the bank whose parities differ from the
   // lower corner's parities by exactly those offsets
   always_comb begin
      for (int c = 0; c < gti_pkg::BANKS; c++) begin
         corners[c] = bank_rd_data[gti_pkg::bank_sel_type'(c) ^ par4_ff];
      end
   end

   gti_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v4_ff),
      .in_ready   (blend_ready),
      .in_corners (corners),
      .in_weights (w4_ff),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_data   (rsp_chan.efficiency)
   );

   // a read always produces a lookup in the access stage
   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> v4_ff)
      else $error("bank read without a waiting lookup");

   // no bank access while the access stage is blocked
   a_no_access_stalled: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !blend_ready |-> !ram_rd_en && !ram_wr_en)
      else $error("bank touched while access stage stalled");

   // stalled lookup keeps its weights and parities
   a_weights_hold: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !blend_ready |=> v4_ff && $stable(w4_ff) && $stable(par4_ff))
      else $error("access stage changed while stalled");

endmodule

`default_nettype wire
